>>> rtl/core/wcs_pkg.sv
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared sizes, codes and handshake structs of the weighted CDF sampler.
// ----------------------------------------------------------------------------
package wcs_pkg;

    // Table capacity and derived widths
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CDF_AW      = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W       = 16 + $clog2(MAX_ENTRIES);
    localparam int CDF_W       = 17;

    // Divider sizes: dividend holds a 16-bit-shifted total, divisor a total
    localparam int DIV_NW      = SUM_W + 16;
    localparam int DIV_DW      = SUM_W;
    localparam int DIV_CW      = $clog2(DIV_NW);

    // Stream payload widths
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 40;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_FULL    = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_ZERO    = 3'd3,
        STS_UNBUILT = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BRD,
        S_BDIV,
        S_BWAIT,
        S_SRCH,
        S_CMP,
        S_RDHI,
        S_RDLO,
        S_NW,
        S_RATIO,
        S_DONE
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/core/wcs_div.sv
// ----------------------------------------------------------------------------
// wcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcs_pkg::div_req_t req,
    output wcs_pkg::div_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [wcs_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [wcs_pkg::DIV_NW-1:0] work_reg, work_next;
    logic [wcs_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [wcs_pkg::DIV_DW-1:0] dvs_reg, dvs_next;
    logic [wcs_pkg::DIV_DW:0]   trial;
    logic [wcs_pkg::DIV_DW:0]   diff;

    // One shift-subtract step; work_reg shifts dividend bits out, quotient in
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, work_reg[wcs_pkg::DIV_NW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (busy_reg) begin
            if (!diff[wcs_pkg::DIV_DW]) begin
                rem_next  = diff[wcs_pkg::DIV_DW-1:0];
                work_next = {work_reg[wcs_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                rem_next  = trial[wcs_pkg::DIV_DW-1:0];
                work_next = {work_reg[wcs_pkg::DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = wcs_pkg::DIV_CW'(wcs_pkg::DIV_NW - 1);
            work_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

>>> rtl/core/weighted_cdf_sampler_core.sv
// ----------------------------------------------------------------------------
// weighted_cdf_sampler_core
// Discrete sampler: entry table, normalized CDF build, binary-search sample.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream: s_tuser is the command (insert, build,
//   sample), s_tdata carries weight, prob and u. Each command produces one
//   result transfer on the m_ stream: status, entry index, span and ratio.
//   One command is worked at a time; s_tready is high while the engine idles.
//   The divider is bit-serial over D bits (D = 36 at 16 entries). Divides per command:
//     insert, unused command, error results: no divide
//     build:  one divide per entry
//     sample: a binary search, then up to two divides
//   The search costs one CDF memory read per step. Entry data and CDF bounds
//   sit in two synchronous memories with registered read ports.
//   A finished result waits in the output register while the next command
//   is taken; if it is still not taken when the next result is ready, the
//   engine holds in its done state until m_tready.
//   Reset clears the entry count, totals and the built flag; no memory
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_cdf_sampler_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] weight, [31:16] prob, [47:32] u
    input  logic [wcs_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] status, [6:3] entry_index, [23:7] span, [39:24] weight_ratio
    output logic [wcs_pkg::M_DATA_W-1:0] m_tdata
);

    wcs_pkg::state_t             state_reg, state_next;
    logic [wcs_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [wcs_pkg::SUM_W-1:0]   wtot_reg, wtot_next;
    logic [wcs_pkg::SUM_W-1:0]   ptot_reg, ptot_next;
    logic                        built_reg, built_next;
    logic [wcs_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [wcs_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [wcs_pkg::IDX_W-1:0]   lo_reg, lo_next;
    logic [wcs_pkg::IDX_W-1:0]   hi_reg, hi_next;
    logic [wcs_pkg::IDX_W-1:0]   mid_reg, mid_next;
    logic [15:0]                 u_reg, u_next;
    logic [wcs_pkg::CDF_W-1:0]   hib_reg, hib_next;
    logic [wcs_pkg::CDF_W-1:0]   nw_reg, nw_next;
    logic [2:0]                  sts_reg, sts_next;
    logic [3:0]                  idx_reg, idx_next;
    logic [wcs_pkg::CDF_W-1:0]   span_reg, span_next;
    logic [15:0]                 ratio_reg, ratio_next;
    logic                        m_valid_reg;
    logic [wcs_pkg::M_DATA_W-1:0] m_data_reg;

    logic                        s_accept;
    logic                        out_load;
    logic [wcs_pkg::IDX_W:0]     mid_sum;
    logic [wcs_pkg::CDF_W-1:0]   span_calc;

    // Entry memory: {prob, weight}
    logic [31:0]                 entry_mem [wcs_pkg::MAX_ENTRIES];
    logic                        ent_we;
    logic [wcs_pkg::IDX_W-1:0]   ent_waddr;
    logic [31:0]                 ent_wdata;
    logic [wcs_pkg::IDX_W-1:0]   ent_raddr;
    logic [31:0]                 ent_rd_reg;

    // CDF memory: bounds 0..n
    logic [wcs_pkg::CDF_W-1:0]   cdf_mem [wcs_pkg::MAX_ENTRIES + 1];
    logic                        cdf_we;
    logic [wcs_pkg::CDF_AW-1:0]  cdf_waddr;
    logic [wcs_pkg::CDF_W-1:0]   cdf_wdata;
    logic [wcs_pkg::CDF_AW-1:0]  cdf_raddr;
    logic [wcs_pkg::CDF_W-1:0]   cdf_rd_reg;

    wcs_pkg::div_req_t           div_req;
    wcs_pkg::div_rsp_t           div_rsp;

    wcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready  = (state_reg == wcs_pkg::S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = (state_reg == wcs_pkg::S_DONE) && (!m_valid_reg || m_tready);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign span_calc = hib_reg - cdf_rd_reg;

    // Next state, memory access and divider control
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        wtot_next  = wtot_reg;
        ptot_next  = ptot_reg;
        built_next = built_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        u_next     = u_reg;
        hib_next   = hib_reg;
        nw_next    = nw_reg;
        sts_next   = sts_reg;
        idx_next   = idx_reg;
        span_next  = span_reg;
        ratio_next = ratio_reg;
        ent_we     = 1'b0;
        ent_waddr  = count_reg[wcs_pkg::IDX_W-1:0];
        ent_wdata  = s_tdata[31:0];
        ent_raddr  = k_reg;
        cdf_we     = 1'b0;
        cdf_waddr  = wcs_pkg::CDF_AW'(k_reg) + wcs_pkg::CDF_AW'(1);
        cdf_wdata  = div_rsp.quotient[wcs_pkg::CDF_W-1:0];
        cdf_raddr  = wcs_pkg::CDF_AW'(mid_reg) + wcs_pkg::CDF_AW'(1);
        div_req.start    = 1'b0;
        div_req.dividend = {acc_reg, 16'd0};
        div_req.divisor  = ptot_reg;

        unique case (state_reg)
            wcs_pkg::S_IDLE: begin
                if (s_accept) begin
                    sts_next   = wcs_pkg::STS_OK;
                    idx_next   = '0;
                    span_next  = '0;
                    ratio_next = '0;
                    u_next     = s_tdata[47:32];
                    state_next = wcs_pkg::S_DONE;
                    unique case (wcs_pkg::cmd_t'(s_tuser))
                        wcs_pkg::CMD_INSERT: begin
                            if (count_reg >= wcs_pkg::CNT_W'(wcs_pkg::MAX_ENTRIES)) begin
                                sts_next = wcs_pkg::STS_FULL;
                            end else begin
                                ent_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                wtot_next  = wtot_reg + wcs_pkg::SUM_W'(s_tdata[15:0]);
                                ptot_next  = ptot_reg + wcs_pkg::SUM_W'(s_tdata[31:16]);
                                built_next = 1'b0;
                            end
                        end
                        wcs_pkg::CMD_BUILD: begin
                            built_next = 1'b0;
                            if (count_reg == '0) begin
                                sts_next = wcs_pkg::STS_EMPTY;
                            end else if (wtot_reg == '0 || ptot_reg == '0) begin
                                sts_next = wcs_pkg::STS_ZERO;
                            end else begin
                                // Lowest bound is always zero
                                cdf_we     = 1'b1;
                                cdf_waddr  = '0;
                                cdf_wdata  = '0;
                                acc_next   = '0;
                                k_next     = '0;
                                state_next = wcs_pkg::S_BRD;
                            end
                        end
                        wcs_pkg::CMD_SAMPLE: begin
                            if (count_reg == '0) begin
                                sts_next = wcs_pkg::STS_EMPTY;
                            end else if (!built_reg || wtot_reg == '0) begin
                                sts_next = wcs_pkg::STS_UNBUILT;
                            end else begin
                                lo_next    = '0;
                                hi_next    = wcs_pkg::IDX_W'(count_reg - 1'b1);
                                state_next = wcs_pkg::S_SRCH;
                            end
                        end
                        default: begin
                            // Unused command: all-zero result
                            sts_next = wcs_pkg::STS_OK;
                        end
                    endcase
                end
            end

            // Build: read entry k, accumulate, divide, store bound k+1
            wcs_pkg::S_BRD: begin
                ent_raddr  = k_reg;
                state_next = wcs_pkg::S_BDIV;
            end
            wcs_pkg::S_BDIV: begin
                acc_next         = acc_reg + wcs_pkg::SUM_W'(ent_rd_reg[31:16]);
                div_req.start    = 1'b1;
                div_req.dividend = {acc_next, 16'd0};
                div_req.divisor  = ptot_reg;
                state_next       = wcs_pkg::S_BWAIT;
            end
            wcs_pkg::S_BWAIT: begin
                if (div_rsp.done) begin
                    cdf_we = 1'b1;
                    if (wcs_pkg::CNT_W'(k_reg) + 1'b1 == count_reg) begin
                        built_next = 1'b1;
                        sts_next   = wcs_pkg::STS_OK;
                        state_next = wcs_pkg::S_DONE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = wcs_pkg::S_BRD;
                    end
                end
            end

            // Sample: binary search on upper bounds
            wcs_pkg::S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[wcs_pkg::IDX_W:1];
                    cdf_raddr  = wcs_pkg::CDF_AW'(mid_next) + wcs_pkg::CDF_AW'(1);
                    state_next = wcs_pkg::S_CMP;
                end else begin
                    cdf_raddr  = wcs_pkg::CDF_AW'(lo_reg) + wcs_pkg::CDF_AW'(1);
                    ent_raddr  = lo_reg;
                    state_next = wcs_pkg::S_RDHI;
                end
            end
            wcs_pkg::S_CMP: begin
                if (cdf_rd_reg < wcs_pkg::CDF_W'(u_reg)) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = wcs_pkg::S_SRCH;
            end
            wcs_pkg::S_RDHI: begin
                hib_next   = cdf_rd_reg;
                cdf_raddr  = wcs_pkg::CDF_AW'(lo_reg);
                // keep the selected entry on the read port
                ent_raddr  = lo_reg;
                state_next = wcs_pkg::S_RDLO;
            end
            wcs_pkg::S_RDLO: begin
                span_next = span_calc;
                idx_next  = 4'(lo_reg);
                if (count_reg == wcs_pkg::CNT_W'(1)) begin
                    ratio_next = 16'd256;
                    state_next = wcs_pkg::S_DONE;
                end else begin
                    // Normalized weight: (w << 16) / weight total
                    div_req.start    = 1'b1;
                    div_req.dividend = wcs_pkg::DIV_NW'({ent_rd_reg[15:0], 16'd0});
                    div_req.divisor  = wtot_reg;
                    state_next       = wcs_pkg::S_NW;
                end
            end
            wcs_pkg::S_NW: begin
                if (div_rsp.done) begin
                    nw_next = div_rsp.quotient[wcs_pkg::CDF_W-1:0];
                    if (span_reg == '0) begin
                        ratio_next = 16'hFFFF;
                        state_next = wcs_pkg::S_DONE;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = wcs_pkg::DIV_NW'({nw_next, 8'd0});
                        div_req.divisor  = wcs_pkg::DIV_DW'(span_reg);
                        state_next       = wcs_pkg::S_RATIO;
                    end
                end
            end
            wcs_pkg::S_RATIO: begin
                if (div_rsp.done) begin
                    if (|div_rsp.quotient[wcs_pkg::DIV_NW-1:16]) begin
                        ratio_next = 16'hFFFF;
                    end else begin
                        ratio_next = div_rsp.quotient[15:0];
                    end
                    state_next = wcs_pkg::S_DONE;
                end
            end
            wcs_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = wcs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wcs_pkg::S_IDLE;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcs_pkg::S_IDLE;
            count_reg <= '0;
            wtot_reg  <= '0;
            ptot_reg  <= '0;
            built_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            wtot_reg  <= wtot_next;
            ptot_reg  <= ptot_next;
            built_reg <= built_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        u_reg     <= u_next;
        hib_reg   <= hib_next;
        nw_reg    <= nw_next;
        sts_reg   <= sts_next;
        idx_reg   <= idx_next;
        span_reg  <= span_next;
        ratio_reg <= ratio_next;
    end

    // Entry memory
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= entry_mem[ent_raddr];
    end

    // CDF memory
    always_ff @(posedge aclk) begin
        if (cdf_we) begin
            cdf_mem[cdf_waddr] <= cdf_wdata;
        end
        cdf_rd_reg <= cdf_mem[cdf_raddr];
    end

    // Output register: holds a result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {ratio_reg, span_reg, idx_reg, sts_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // Entry count never passes the table size
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= wcs_pkg::CNT_W'(wcs_pkg::MAX_ENTRIES))
        else $error("entry count above table size");

    // A built table always has entries and nonzero totals
    a_built_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        built_reg |-> (count_reg != '0 && wtot_reg != '0 && ptot_reg != '0))
        else $error("built flag set on an invalid table");

    // Divider is never restarted while busy
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Output register is loaded only when free or draining
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");
`endif

endmodule
